// ----- src/obd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obd_pkg
// Shared types, constants and the Bayer threshold lookup for the ordered
// dither block.
// ----------------------------------------------------------------------------
package obd_pkg;

    localparam int TILE_SIZE    = 16;
    localparam int TILE_BITS    = $clog2(TILE_SIZE);
    localparam int MAX_CHANNELS = 4;
    localparam int MIN_CHANNELS = 3;
    localparam int CHAN_W       = 8;
    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int OFF_W        = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd1;

    // rounding constant and divisor of the offset scaling
    localparam logic [15:0] ROUND_ADD = 16'd127;
    localparam logic [8:0]  SCALE_DIV = 9'd255;
    localparam logic [7:0]  CHAN_MAX  = 8'd255;

    typedef logic [MAX_CHANNELS-1:0][CHAN_W-1:0] t_pixel;

    typedef struct packed {
        logic signed [OFF_W-1:0] offset;
        t_pixel                  pix;
    } t_stage;

    // Recursive 16x16 Bayer matrix: each level of the coordinates contributes
    // two value bits, (col ^ row) above row, lowest coordinate level on top.
    function automatic logic [7:0] bayer_value(
        input logic [TILE_BITS-1:0] row,
        input logic [TILE_BITS-1:0] col
    );
        logic [7:0] v;
        v = '0;
        for (int k = 0; k < TILE_BITS; k++) begin
            v[7-2*k] = col[k] ^ row[k];
            v[6-2*k] = row[k];
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- src/obd_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obd_pix_if
// Pixel request channel: valid/ready with four channels and line/frame marks.
// ----------------------------------------------------------------------------
interface obd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_chan0;
    logic [7:0] in_chan1;
    logic [7:0] in_chan2;
    logic [7:0] in_chan3;
    logic       end_of_line;
    logic       end_of_frame;

    modport source (
        output valid, in_chan0, in_chan1, in_chan2, in_chan3, end_of_line, end_of_frame,
        input  ready
    );
    modport sink (
        input  valid, in_chan0, in_chan1, in_chan2, in_chan3, end_of_line, end_of_frame,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/obd_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obd_res_if
// Result request channel: valid/ready with four dithered channels.
// ----------------------------------------------------------------------------
interface obd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic [7:0] out_chan3;

    modport source (
        output valid, out_chan0, out_chan1, out_chan2, out_chan3,
        input  ready
    );
    modport sink (
        input  valid, out_chan0, out_chan1, out_chan2, out_chan3,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/obd_offset.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obd_offset
// Tile phase counters and a three-stage offset pipeline: threshold lookup,
// scale multiply, divide by 255 and centring. The pixel travels alongside.
// ----------------------------------------------------------------------------
module obd_offset (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire obd_pkg::t_pixel      i_pix,
    input  wire logic                 i_eol,
    input  wire logic                 i_eof,
    input  wire logic [7:0]           i_amt_m1,
    input  wire logic                 i_adv,
    output logic                      o_valid,
    output obd_pkg::t_stage           o_stage
);

    logic [obd_pkg::TILE_BITS-1:0] r_col;
    logic [obd_pkg::TILE_BITS-1:0] r_row;

    logic                          r_v1, r_v2, r_v3;
    logic [7:0]                    r_b1, r_a1;
    obd_pkg::t_pixel               r_pix1, r_pix2, r_pix3;
    logic [15:0]                   r_x2;
    logic [6:0]                    r_ah2;
    logic signed [obd_pkg::OFF_W-1:0] r_off3;

    logic        en1, en2, en3, acc;
    logic [15:0] n_x2;
    logic [7:0]  q0;
    logic [8:0]  rem;
    logic [7:0]  n_q;

    assign en3     = !r_v3 || i_adv;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign acc     = i_valid && en1;

    // phases advance once per accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (i_eof) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_eol) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // x / 255 with x <= 255*255 + 127: x>>8 undershoots by at most one, and the
    // remainder stays below twice the divisor
    assign n_x2 = 16'(r_b1 * r_a1) + obd_pkg::ROUND_ADD;
    assign q0   = r_x2[15:8];
    assign rem  = {1'b0, r_x2[7:0]} + {1'b0, q0};
    assign n_q  = (rem >= obd_pkg::SCALE_DIV) ? q0 + 8'd1 : q0;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_b1   <= obd_pkg::bayer_value(r_row, r_col);
            r_a1   <= i_amt_m1;
            r_pix1 <= i_pix;
        end
        if (en2) begin
            r_x2   <= n_x2;
            r_ah2  <= r_a1[7:1];
            r_pix2 <= r_pix1;
        end
        if (en3) begin
            r_off3 <= $signed({1'b0, n_q}) - $signed({2'b00, r_ah2});
            r_pix3 <= r_pix2;
        end
    end

    assign o_valid        = r_v3;
    assign o_stage.offset = r_off3;
    assign o_stage.pix    = r_pix3;

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_eof |=> r_col == '0 && r_row == '0)
        else $error("phases not cleared at end of frame");

    a_eol_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_eol && !i_eof |=> r_col == '0 && r_row == $past(r_row) + 1'b1)
        else $error("row phase did not advance at end of line");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_adv |=> r_v3 && $stable(r_off3))
        else $error("last offset stage lost its item while stalled");

endmodule
`default_nettype wire

// ----- src/obd_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obd_lane
// One channel lane: add the offset and saturate to 0..255, or pass the value
// through when the channel is not dithered.
// ----------------------------------------------------------------------------
module obd_lane (
    input  wire logic                          i_active,
    input  wire logic [7:0]                    i_val,
    input  wire logic signed [obd_pkg::OFF_W-1:0] i_off,
    output logic [7:0]                         o_val
);

    logic signed [obd_pkg::OFF_W:0] sum;

    assign sum = $signed({2'b00, i_val}) + $signed({i_off[obd_pkg::OFF_W-1], i_off});

    always_comb begin
        if (!i_active) begin
            o_val = i_val;
        end else if (sum < 0) begin
            o_val = '0;
        end else if (sum > $signed({2'b00, obd_pkg::CHAN_MAX})) begin
            o_val = obd_pkg::CHAN_MAX;
        end else begin
            o_val = sum[7:0];
        end
    end

endmodule
`default_nettype wire

// ----- src/ordered_bayer_dither_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted pixel passes the obd_offset stages and the output register to o_res.
// Throughput: one pixel per cycle; ready drops only when the output
// register holds a result that is not taken and every stage behind it is full.
// Reset (synchronous, active low) clears the tile phases, all stage valid
// bits and the output valid bit; amount returns to 1 and channels to 3.
// ----------------------------------------------------------------------------
// ordered_bayer_dither_top
// 16x16 ordered dither of a raster pixel stream: offset pipeline, four
// channel lanes and a merging output register.
// ----------------------------------------------------------------------------
module ordered_bayer_dither_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [obd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [obd_pkg::CFG_W-1:0]       i_cfg_data,
    obd_pix_if.sink                              i_pix,
    obd_res_if.source                            o_res
);

    logic [7:0]       r_amt_m1;
    logic             r_four;
    logic             r_vo;
    obd_pkg::t_pixel  r_res;

    logic             en_out;
    logic             w_valid;
    obd_pkg::t_stage  w_stage;
    obd_pkg::t_pixel  w_pix_in;
    obd_pkg::t_pixel  w_lane;
    logic [obd_pkg::MAX_CHANNELS-1:0] w_act;

    // amount register stores amount-1, clamped to 0..255
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amt_m1 <= '0;
            r_four   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                obd_pkg::CFG_AMOUNT: begin
                    if (i_cfg_data == '0)
                        r_amt_m1 <= '0;
                    else if (i_cfg_data[8])
                        r_amt_m1 <= 8'hFF;
                    else
                        r_amt_m1 <= i_cfg_data[7:0] - 8'd1;
                end
                obd_pkg::CFG_CHANNELS: begin
                    r_four <= i_cfg_data[2:0] inside {[3'd4:3'd7]};
                end
                default: begin
                end
            endcase
        end
    end

    assign w_pix_in[0] = i_pix.in_chan0;
    assign w_pix_in[1] = i_pix.in_chan1;
    assign w_pix_in[2] = i_pix.in_chan2;
    assign w_pix_in[3] = i_pix.in_chan3;

    assign en_out = !r_vo || o_res.ready;

    obd_offset u_offset (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_pix.valid),
        .o_ready  (i_pix.ready),
        .i_pix    (w_pix_in),
        .i_eol    (i_pix.end_of_line),
        .i_eof    (i_pix.end_of_frame),
        .i_amt_m1 (r_amt_m1),
        .i_adv    (en_out),
        .o_valid  (w_valid),
        .o_stage  (w_stage)
    );

    for (genvar g = 0; g < obd_pkg::MAX_CHANNELS; g++) begin : g_lane
        assign w_act[g] = (g < obd_pkg::MIN_CHANNELS) ? 1'b1 : r_four;
        obd_lane u_lane (
            .i_active (w_act[g]),
            .i_val    (w_stage.pix[g]),
            .i_off    (w_stage.offset),
            .o_val    (w_lane[g])
        );
    end

    // merge the lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en_out) begin
            r_vo <= w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) r_res <= w_lane;
    end

    assign o_res.valid     = r_vo;
    assign o_res.out_chan0 = r_res[0];
    assign o_res.out_chan1 = r_res[1];
    assign o_res.out_chan2 = r_res[2];
    assign o_res.out_chan3 = r_res[3];

    a_amt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == obd_pkg::CFG_AMOUNT && i_cfg_data == '0
        |=> r_amt_m1 == '0)
        else $error("amount zero not treated as one");

    a_amt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == obd_pkg::CFG_AMOUNT && i_cfg_data[8]
        |=> r_amt_m1 == 8'hFF)
        else $error("amount above 256 not saturated");

    a_pass_fourth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid && !r_four |-> w_lane[3] == w_stage.pix[3])
        else $error("fourth channel altered with three channels active");

endmodule
`default_nettype wire
